>>> sv/hcl_pkg.sv
package hcl_pkg;

  localparam int DEF_MAX_SYMBOLS = 1024;
  localparam int DEF_HIST_CAP    = 32;

  localparam int REQ_W  = 2;
  localparam int FREQ_W = 16;
  localparam int IDX_W  = 10;
  localparam int KIND_W = 2;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 11;
  localparam int SUM_W  = 26;
  // Symbol positions and counts at the largest supported symbol capacity.
  localparam int SYM_W  = 12;
  localparam int EXT_W  = 13;

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEN  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HIST = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEN     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIST    = 2'd2;

  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  pos;
    logic [SYM_W-1:0]  sym;
    logic [FREQ_W-1:0] freq;
  } hcl_fill_t;

  typedef struct packed {
    logic             go;
    logic [EXT_W-1:0] n;
  } hcl_start_t;

endpackage

>>> sv/hcl_engine.sv
module hcl_engine
  import hcl_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hcl_fill_t                      fill,
  input  hcl_start_t                     start,
  input  logic [$clog2(MAX_SYMBOLS)-1:0] rd_addr,
  output logic [SUM_W-1:0]               rd_val,
  output logic [$clog2(MAX_SYMBOLS)-1:0] rd_sym,
  output logic                           done
);

  localparam int IW = $clog2(MAX_SYMBOLS);
  localparam int NW = IW + 1;

  localparam logic signed [NW:0] ONE_S = (NW+1)'(1);
  localparam logic signed [NW:0] TWO_S = (NW+1)'(2);
  localparam logic signed [NW:0] THR_S = (NW+1)'(3);
  localparam logic signed [NW:0] ZER_S = '0;

  localparam logic [4:0] E_IDLE = 5'd0;
  localparam logic [4:0] S_RI   = 5'd1;
  localparam logic [4:0] S_RI2  = 5'd2;
  localparam logic [4:0] S_RJ   = 5'd3;
  localparam logic [4:0] S_CJ   = 5'd4;
  localparam logic [4:0] S_PUT  = 5'd5;
  localparam logic [4:0] M_0    = 5'd6;
  localparam logic [4:0] M_1    = 5'd7;
  localparam logic [4:0] M_2    = 5'd8;
  localparam logic [4:0] M_A    = 5'd9;
  localparam logic [4:0] M_B    = 5'd10;
  localparam logic [4:0] M_C    = 5'd11;
  localparam logic [4:0] M_D    = 5'd12;
  localparam logic [4:0] M_E    = 5'd13;
  localparam logic [4:0] M_F    = 5'd14;
  localparam logic [4:0] M_G    = 5'd15;
  localparam logic [4:0] M_H    = 5'd16;
  localparam logic [4:0] M_I    = 5'd17;
  localparam logic [4:0] Q_0    = 5'd18;
  localparam logic [4:0] Q_A    = 5'd19;
  localparam logic [4:0] Q_B    = 5'd20;
  localparam logic [4:0] Q_C    = 5'd21;
  localparam logic [4:0] R_0    = 5'd22;
  localparam logic [4:0] R_A    = 5'd23;
  localparam logic [4:0] R_B    = 5'd24;
  localparam logic [4:0] R_C    = 5'd25;

  logic [SUM_W-1:0] wa_mem [MAX_SYMBOLS];
  logic [IW-1:0]    ss_mem [MAX_SYMBOLS];
  logic [SUM_W-1:0] wa_rd_r;
  logic [IW-1:0]    ss_rd_r;

  logic             wa_we, ss_we;
  logic [IW-1:0]    wa_wa, ra;
  logic [SUM_W-1:0] wa_wd;
  logic [IW-1:0]    ss_wd;

  logic [4:0]        st_r, st_nxt;
  logic [NW-1:0]     n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, jm1, dpth_r, dpth_nxt;
  logic signed [NW:0] root_r, root_nxt, leaf_r, leaf_nxt, next_r, next_nxt, n_s;
  logic [NW:0]       avbl_r, avbl_nxt, used_r, used_nxt;
  logic [SUM_W-1:0]  f_r, f_nxt, va_r, va_nxt, tmp_r, tmp_nxt;
  logic [IW-1:0]     s_r, s_nxt;

  always_ff @(posedge clk) begin
    if (wa_we) wa_mem[wa_wa] <= wa_wd;
    if (ss_we) ss_mem[wa_wa] <= ss_wd;
    wa_rd_r <= wa_mem[ra];
    ss_rd_r <= ss_mem[ra];
  end

  assign rd_val = wa_rd_r;
  assign rd_sym = ss_rd_r;
  assign n_s    = $signed({1'b0, n_r});
  assign jm1    = j_r - NW'(1);

  always_comb begin
    st_nxt = st_r;  n_nxt = n_r;  i_nxt = i_r;  j_nxt = j_r;  dpth_nxt = dpth_r;
    root_nxt = root_r;  leaf_nxt = leaf_r;  next_nxt = next_r;
    avbl_nxt = avbl_r;  used_nxt = used_r;
    f_nxt = f_r;  va_nxt = va_r;  tmp_nxt = tmp_r;  s_nxt = s_r;
    wa_we = 1'b0;  ss_we = 1'b0;  wa_wa = '0;  wa_wd = '0;  ss_wd = '0;
    ra = rd_addr;  done = 1'b0;
    unique case (st_r)
      E_IDLE: begin
        if (fill.en) begin
          wa_we = 1'b1;
          ss_we = 1'b1;
          wa_wa = fill.pos[IW-1:0];
          wa_wd = SUM_W'(fill.freq);
          ss_wd = fill.sym[IW-1:0];
        end
        if (start.go) begin
          n_nxt  = start.n[NW-1:0];
          i_nxt  = NW'(1);
          st_nxt = S_RI;
        end
      end
      // Stable insertion sort, comparing and shifting one element at a time.
      S_RI: begin
        ra = i_r[IW-1:0];
        st_nxt = S_RI2;
      end
      S_RI2: begin
        f_nxt = wa_rd_r;
        s_nxt = ss_rd_r;
        j_nxt = i_r;
        st_nxt = S_RJ;
      end
      S_RJ: begin
        ra = jm1[IW-1:0];
        st_nxt = S_CJ;
      end
      S_CJ: begin
        if (wa_rd_r > f_r) begin
          wa_we = 1'b1;  ss_we = 1'b1;
          wa_wa = j_r[IW-1:0];
          wa_wd = wa_rd_r;
          ss_wd = ss_rd_r;
          j_nxt = jm1;
          st_nxt = (jm1 != '0) ? S_RJ : S_PUT;
        end else begin
          st_nxt = S_PUT;
        end
      end
      S_PUT: begin
        wa_we = 1'b1;  ss_we = 1'b1;
        wa_wa = j_r[IW-1:0];
        wa_wd = f_r;
        ss_wd = s_r;
        i_nxt = i_r + NW'(1);
        st_nxt = ((i_r + NW'(1)) < n_r) ? S_RI : M_0;
      end
      // Tree building pass.
      M_0: begin
        ra = '0;
        st_nxt = M_1;
      end
      M_1: begin
        va_nxt = wa_rd_r;
        ra = IW'(1);
        st_nxt = M_2;
      end
      M_2: begin
        wa_we = 1'b1;
        wa_wa = '0;
        wa_wd = va_r + wa_rd_r;
        root_nxt = ZER_S;
        leaf_nxt = TWO_S;
        next_nxt = ONE_S;
        st_nxt = (ONE_S < n_s - ONE_S) ? M_A : Q_0;
      end
      M_A: begin
        ra = root_r[IW-1:0];
        st_nxt = M_B;
      end
      M_B: begin
        va_nxt = wa_rd_r;
        ra = leaf_r[IW-1:0];
        st_nxt = M_C;
      end
      M_C: begin
        wa_we = 1'b1;
        wa_wa = next_r[IW-1:0];
        if (leaf_r >= n_s || va_r < wa_rd_r) begin
          wa_wd = va_r;
          tmp_nxt = va_r;
          st_nxt = M_D;
        end else begin
          wa_wd = wa_rd_r;
          tmp_nxt = wa_rd_r;
          leaf_nxt = leaf_r + ONE_S;
          st_nxt = M_E;
        end
      end
      M_D: begin
        wa_we = 1'b1;
        wa_wa = root_r[IW-1:0];
        wa_wd = SUM_W'(next_r);
        root_nxt = root_r + ONE_S;
        st_nxt = M_E;
      end
      M_E: begin
        ra = root_r[IW-1:0];
        st_nxt = M_F;
      end
      M_F: begin
        va_nxt = wa_rd_r;
        ra = leaf_r[IW-1:0];
        st_nxt = M_G;
      end
      M_G: begin
        wa_we = 1'b1;
        wa_wa = next_r[IW-1:0];
        if (leaf_r >= n_s || (root_r < next_r && va_r < wa_rd_r)) begin
          wa_wd = tmp_r + va_r;
          st_nxt = M_H;
        end else begin
          wa_wd = tmp_r + wa_rd_r;
          leaf_nxt = leaf_r + ONE_S;
          st_nxt = M_I;
        end
      end
      M_H: begin
        wa_we = 1'b1;
        wa_wa = root_r[IW-1:0];
        wa_wd = SUM_W'(next_r);
        root_nxt = root_r + ONE_S;
        st_nxt = M_I;
      end
      M_I: begin
        next_nxt = next_r + ONE_S;
        st_nxt = (next_r + ONE_S < n_s - ONE_S) ? M_A : Q_0;
      end
      // Parent pointers become node depths.
      Q_0: begin
        wa_we = 1'b1;
        wa_wa = IW'(n_r - NW'(2));
        wa_wd = '0;
        next_nxt = n_s - THR_S;
        st_nxt = (n_s - THR_S >= ZER_S) ? Q_A : R_0;
      end
      Q_A: begin
        ra = next_r[IW-1:0];
        st_nxt = Q_B;
      end
      Q_B: begin
        if (wa_rd_r < SUM_W'(n_r)) begin
          ra = wa_rd_r[IW-1:0];
          st_nxt = Q_C;
        end else begin
          wa_we = 1'b1;
          wa_wa = next_r[IW-1:0];
          wa_wd = SUM_W'(1);
          next_nxt = next_r - ONE_S;
          st_nxt = (next_r - ONE_S >= ZER_S) ? Q_A : R_0;
        end
      end
      Q_C: begin
        wa_we = 1'b1;
        wa_wa = next_r[IW-1:0];
        wa_wd = wa_rd_r + SUM_W'(1);
        next_nxt = next_r - ONE_S;
        st_nxt = (next_r - ONE_S >= ZER_S) ? Q_A : R_0;
      end
      // Internal depths become leaf depths.
      R_0: begin
        avbl_nxt = (NW+1)'(1);
        used_nxt = '0;
        dpth_nxt = '0;
        root_nxt = n_s - TWO_S;
        next_nxt = n_s - ONE_S;
        st_nxt = R_A;
      end
      R_A: begin
        if (root_r >= ZER_S) begin
          ra = root_r[IW-1:0];
          st_nxt = R_B;
        end else begin
          st_nxt = R_C;
        end
      end
      R_B: begin
        if (wa_rd_r == SUM_W'(dpth_r)) begin
          used_nxt = used_r + (NW+1)'(1);
          root_nxt = root_r - ONE_S;
          st_nxt = R_A;
        end else begin
          st_nxt = R_C;
        end
      end
      R_C: begin
        if (avbl_r > used_r && next_r >= ZER_S) begin
          wa_we = 1'b1;
          wa_wa = next_r[IW-1:0];
          wa_wd = SUM_W'(dpth_r);
          next_nxt = next_r - ONE_S;
          avbl_nxt = avbl_r - (NW+1)'(1);
        end else begin
          avbl_nxt = used_r << 1;
          dpth_nxt = dpth_r + NW'(1);
          used_nxt = '0;
          if (used_r == '0) begin
            done = 1'b1;
            st_nxt = E_IDLE;
          end else begin
            st_nxt = R_A;
          end
        end
      end
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r <= n_nxt;  i_r <= i_nxt;  j_r <= j_nxt;  dpth_r <= dpth_nxt;
    root_r <= root_nxt;  leaf_r <= leaf_nxt;  next_r <= next_nxt;
    avbl_r <= avbl_nxt;  used_r <= used_nxt;
    f_r <= f_nxt;  va_r <= va_nxt;  tmp_r <= tmp_nxt;  s_r <= s_nxt;
  end

endmodule

>>> sv/huffman_code_length_generator.sv
// Huffman code length generator. Frequencies are loaded one per transaction, the
// symbol index being the position of the load in the set; a load with in_last high
// closes the set, and busy then rises while the block clears the previous lengths
// and histogram, gathers the used symbols, sorts them by stable insertion sort,
// runs the in-place minimum-redundancy passes over the work memory and writes
// lengths and histogram back; after an overflowing set only the clearing is done.
// The summary transaction is strobed in the first cycle in which busy is low
// again. Loads, code length reads and histogram reads are otherwise taken one per
// cycle, a read's result appearing on the out_ ports in the cycle after acceptance,
// as the memories are read through a register.
// There is no back pressure on the result side: every result is shown for exactly
// one cycle with out_valid high and must be taken then. After reset busy stays high
// for the same clearing sweep of the length memory and the histogram.
module huffman_code_length_generator
  import hcl_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int HIST_CAP    = DEF_HIST_CAP
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [FREQ_W-1:0] in_freq,
  input  logic              in_last,
  input  logic [IDX_W-1:0]  in_index,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic              out_status,
  output logic [LEN_W-1:0]  out_code_length,
  output logic [CNT_W-1:0]  out_hist_count,
  output logic [SUM_W-1:0]  out_freq_total,
  output logic [LEN_W-1:0]  out_max_len
);

  localparam int IW    = $clog2(MAX_SYMBOLS);
  localparam int NW    = IW + 1;
  localparam int HW    = $clog2(HIST_CAP + 1);
  localparam int CLR_N = (MAX_SYMBOLS > HIST_CAP + 1) ? MAX_SYMBOLS : HIST_CAP + 1;
  localparam int CW    = $clog2(CLR_N + 1);

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_CLR  = 4'd1;
  localparam logic [3:0] T_GATH = 4'd2;
  localparam logic [3:0] T_ONE  = 4'd3;
  localparam logic [3:0] T_ENG  = 4'd4;
  localparam logic [3:0] T_OA   = 4'd5;
  localparam logic [3:0] T_OB   = 4'd6;
  localparam logic [3:0] T_OC   = 4'd7;
  localparam logic [3:0] T_SUM  = 4'd8;

  // Frequencies of the set being loaded, the per-symbol lengths of the last
  // completed set and its length histogram.
  logic [FREQ_W-1:0] freq_mem [MAX_SYMBOLS];
  logic [LEN_W-1:0]  len_mem  [MAX_SYMBOLS];
  logic [CNT_W-1:0]  hist_mem [HIST_CAP+1];

  logic              fq_we, len_we, hist_we;
  logic [IW-1:0]     fq_wa, fq_ra, len_wa, len_ra;
  logic [LEN_W-1:0]  len_wd;
  logic [HW-1:0]     hist_wa, hist_ra;
  logic [CNT_W-1:0]  hist_wd;
  logic [FREQ_W-1:0] fq_rd_r;
  logic [LEN_W-1:0]  len_rd_r;
  logic [CNT_W-1:0]  hist_rd_r;

  always_ff @(posedge clk) begin
    if (fq_we)   freq_mem[fq_wa]   <= in_freq;
    if (len_we)  len_mem[len_wa]   <= len_wd;
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    fq_rd_r   <= freq_mem[fq_ra];
    len_rd_r  <= len_mem[len_ra];
    hist_rd_r <= hist_mem[hist_ra];
  end

  logic [3:0]        st_r, st_nxt;
  logic              post_r, post_nxt;
  logic [NW-1:0]     lc_r, lc_nxt, g_r, g_nxt, nu_r, nu_nxt, oi_r, oi_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  lng_r, lng_nxt;
  logic [CW-1:0]     clr_r, clr_nxt;
  logic              gv_r, gv_nxt;
  logic [IW-1:0]     gi_r, gi_nxt, first_r, first_nxt, sym_r, sym_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt, lenv;
  logic [HW-1:0]     bin_r, bin_nxt, binv;

  logic              ov_r, ov_nxt, orng_r, orng_nxt, ostat_r, ostat_nxt;
  logic [KIND_W-1:0] okind_r, okind_nxt;
  logic [SUM_W-1:0]  osum_r, osum_nxt;
  logic [LEN_W-1:0]  omax_r, omax_nxt;

  logic              accept;
  logic [EXT_W-1:0]  idx_ext;

  hcl_fill_t         fill;
  hcl_start_t        eng_start;
  logic [IW-1:0]     eng_ra;
  logic [SUM_W-1:0]  eng_val;
  logic [IW-1:0]     eng_sym;
  logic              eng_done;

  hcl_engine #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fill    (fill),
    .start   (eng_start),
    .rd_addr (eng_ra),
    .rd_val  (eng_val),
    .rd_sym  (eng_sym),
    .done    (eng_done)
  );

  assign busy    = (st_r != T_IDLE);
  assign accept  = start && !busy;
  assign idx_ext = EXT_W'(in_index);
  assign lenv    = eng_val[LEN_W-1:0];
  assign binv    = (32'(lenv) >= HIST_CAP) ? HW'(HIST_CAP) : HW'(lenv);

  always_comb begin
    st_nxt = st_r;  post_nxt = post_r;  lc_nxt = lc_r;  g_nxt = g_r;  nu_nxt = nu_r;
    oi_nxt = oi_r;  sum_nxt = sum_r;  ovf_nxt = ovf_r;  lng_nxt = lng_r;  clr_nxt = clr_r;
    gv_nxt = 1'b0;  gi_nxt = gi_r;  first_nxt = first_r;  sym_nxt = sym_r;
    len_nxt = len_r;  bin_nxt = bin_r;
    ov_nxt = 1'b0;  orng_nxt = orng_r;  ostat_nxt = ostat_r;  okind_nxt = okind_r;
    osum_nxt = osum_r;  omax_nxt = omax_r;
    fq_we = 1'b0;  fq_wa = lc_r[IW-1:0];  fq_ra = g_r[IW-1:0];
    len_we = 1'b0;  len_wa = '0;  len_wd = '0;  len_ra = idx_ext[IW-1:0];
    hist_we = 1'b0;  hist_wa = '0;  hist_wd = '0;  hist_ra = idx_ext[HW-1:0];
    fill = '0;  eng_start = '0;  eng_ra = oi_r[IW-1:0];
    unique case (st_r)
      T_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_LOAD: begin
              if (lc_r < NW'(MAX_SYMBOLS)) begin
                fq_we   = 1'b1;
                lc_nxt  = lc_r + NW'(1);
                sum_nxt = sum_r + SUM_W'(in_freq);
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_last) begin
                lng_nxt = '0;
                clr_nxt = '0;
                st_nxt  = T_CLR;
              end
            end
            REQ_LEN: begin
              ov_nxt    = 1'b1;
              okind_nxt = KIND_LEN;
              orng_nxt  = (idx_ext < EXT_W'(MAX_SYMBOLS));
            end
            REQ_HIST: begin
              ov_nxt    = 1'b1;
              okind_nxt = KIND_HIST;
              orng_nxt  = (idx_ext <= EXT_W'(HIST_CAP));
            end
            default: ;
          endcase
        end
      end
      // Sweep clearing the lengths and the histogram of the previous set.
      T_CLR: begin
        len_we  = (clr_r < CW'(MAX_SYMBOLS));
        len_wa  = clr_r[IW-1:0];
        hist_we = (clr_r <= CW'(HIST_CAP));
        hist_wa = clr_r[HW-1:0];
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CLR_N - 1)) begin
          g_nxt  = '0;
          nu_nxt = '0;
          if (post_r) begin
            post_nxt = 1'b0;
            st_nxt   = T_IDLE;
          end else if (ovf_r) begin
            st_nxt = T_SUM;
          end else begin
            st_nxt = T_GATH;
          end
        end
      end
      // Stream the loaded frequencies and pack the nonzero ones into the engine.
      T_GATH: begin
        if (g_r < lc_r) begin
          gv_nxt = 1'b1;
          gi_nxt = g_r[IW-1:0];
          g_nxt  = g_r + NW'(1);
        end
        if (gv_r && fq_rd_r != '0) begin
          fill.en   = 1'b1;
          fill.pos  = SYM_W'(nu_r);
          fill.sym  = SYM_W'(gi_r);
          fill.freq = fq_rd_r;
          nu_nxt    = nu_r + NW'(1);
          first_nxt = gi_r;
        end
        if (g_r >= lc_r && !gv_r) begin
          if (nu_r == '0) begin
            st_nxt = T_SUM;
          end else if (nu_r == NW'(1)) begin
            st_nxt = T_ONE;
          end else begin
            eng_start.go = 1'b1;
            eng_start.n  = EXT_W'(nu_r);
            st_nxt       = T_ENG;
          end
        end
      end
      // A lone used symbol gets length one and stays out of the histogram.
      T_ONE: begin
        len_we  = 1'b1;
        len_wa  = first_r;
        len_wd  = LEN_W'(1);
        lng_nxt = LEN_W'(1);
        st_nxt  = T_SUM;
      end
      T_ENG: begin
        oi_nxt = '0;
        if (eng_done) st_nxt = T_OA;
      end
      T_OA: begin
        st_nxt = T_OB;
      end
      T_OB: begin
        hist_ra = binv;
        bin_nxt = binv;
        len_nxt = lenv;
        sym_nxt = eng_sym;
        if (lenv > lng_r) lng_nxt = lenv;
        st_nxt = T_OC;
      end
      T_OC: begin
        hist_we = 1'b1;
        hist_wa = bin_r;
        hist_wd = hist_rd_r + CNT_W'(1);
        len_we  = 1'b1;
        len_wa  = sym_r;
        len_wd  = len_r;
        oi_nxt  = oi_r + NW'(1);
        st_nxt  = ((oi_r + NW'(1)) < nu_r) ? T_OA : T_SUM;
      end
      T_SUM: begin
        ov_nxt    = 1'b1;
        okind_nxt = KIND_SUMMARY;
        ostat_nxt = ovf_r;
        osum_nxt  = ovf_r ? '0 : sum_r;
        omax_nxt  = lng_r;
        lc_nxt    = '0;
        sum_nxt   = '0;
        ovf_nxt   = 1'b0;
        st_nxt    = T_IDLE;
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= T_CLR;
      post_r <= 1'b1;
      clr_r  <= '0;
      lc_r   <= '0;
      sum_r  <= '0;
      ovf_r  <= 1'b0;
      lng_r  <= '0;
      gv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      post_r <= post_nxt;
      clr_r  <= clr_nxt;
      lc_r   <= lc_nxt;
      sum_r  <= sum_nxt;
      ovf_r  <= ovf_nxt;
      lng_r  <= lng_nxt;
      gv_r   <= gv_nxt;
      ov_r   <= ov_nxt;
    end
    g_r <= g_nxt;  nu_r <= nu_nxt;  oi_r <= oi_nxt;  gi_r <= gi_nxt;
    first_r <= first_nxt;  sym_r <= sym_nxt;  len_r <= len_nxt;  bin_r <= bin_nxt;
    orng_r <= orng_nxt;  ostat_r <= ostat_nxt;  okind_r <= okind_nxt;
    osum_r <= osum_nxt;  omax_r <= omax_nxt;
  end

  // Fields that do not belong to the kind of the transaction read as zero.
  assign out_valid       = ov_r;
  assign out_kind        = ov_r ? okind_r : KIND_SUMMARY;
  assign out_status      = (ov_r && okind_r == KIND_SUMMARY) ? ostat_r : 1'b0;
  assign out_code_length = (ov_r && okind_r == KIND_LEN && orng_r) ? len_rd_r : '0;
  assign out_hist_count  = (ov_r && okind_r == KIND_HIST && orng_r) ? hist_rd_r : '0;
  assign out_freq_total  = (ov_r && okind_r == KIND_SUMMARY) ? osum_r : '0;
  assign out_max_len     = (ov_r && okind_r == KIND_SUMMARY) ? omax_r : '0;

endmodule
